FILE: design/ptpl_pkg.sv
// Shared definitions for the point-to-polyline nearest segment block.
// Holds widths, constants and the sequencer state type; depends on nothing.
`default_nettype none

package ptpl_pkg;

  localparam int MAX_POINTS_DEF = 1024;

  // Port field widths.
  localparam int COORD_W = 32;
  localparam int DIST_W  = 33;
  localparam int IDX_W   = 10;

  // Datapath widths.
  localparam int FRAC_W  = 16;   // fraction bits of Q16.16 and of u
  localparam int DIFF_W  = 33;   // exact coordinate difference
  localparam int MAG_W   = 32;   // magnitude of a difference
  localparam int EMAG_W  = 49;   // magnitude of an error component (Q16.32)
  localparam int U_W     = 17;   // projection parameter, 0..65536
  localparam int MUL_A_W = 49;
  localparam int MUL_B_W = 17;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int SH_W    = 6;
  localparam int ACC_W   = 100;
  localparam int MSQ_W   = 65;   // squared segment length
  localparam int REM_W   = 66;   // divider remainder
  localparam int SUB_W   = 67;   // operands of the shared subtractor
  localparam int SQ_W    = 64;   // squared distance
  localparam int STEP_W  = 5;

  localparam logic [U_W-1:0]   U_ONE      = 17'd65536;
  localparam logic [U_W-1:0]   AT_END_MIN = 17'd65530;
  localparam logic [MSQ_W-1:0] DEGEN_MAX  = 65'd4;
  localparam logic [SQ_W-1:0]  SQRT_ONE   = 64'h4000_0000_0000_0000;

  // Last step of each sequencer phase.
  localparam logic [STEP_W-1:0] MAG_LAST  = 5'd4;
  localparam logic [STEP_W-1:0] DOT_LAST  = 5'd4;
  localparam logic [STEP_W-1:0] DIV_LAST  = 5'd15;
  localparam logic [STEP_W-1:0] ERR_LAST  = 5'd3;
  localparam logic [STEP_W-1:0] SQ_LAST   = 5'd6;
  localparam logic [STEP_W-1:0] SQRT_LAST = 5'd31;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_MAG,
    ST_DOT,
    ST_DECIDE,
    ST_DIV,
    ST_ERR,
    ST_SQ,
    ST_UPD,
    ST_FINAL,
    ST_SQRT,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

FILE: design/ptpl_if.sv
// Valid/ready channel interfaces for vertex requests and distance results.
// Field widths come from ptpl_pkg.
`default_nettype none

interface ptpl_vertex_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ptpl_pkg::COORD_W-1:0]  point_x;
  logic signed [ptpl_pkg::COORD_W-1:0]  point_y;
  logic signed [ptpl_pkg::COORD_W-1:0]  query_x;
  logic signed [ptpl_pkg::COORD_W-1:0]  query_y;
  logic                                 first_point;
  logic                                 last_point;

  modport source (
    output valid, point_x, point_y, query_x, query_y, first_point, last_point,
    input  ready
  );
  modport sink (
    input  valid, point_x, point_y, query_x, query_y, first_point, last_point,
    output ready
  );
endinterface

interface ptpl_result_if;
  logic                           valid;
  logic                           ready;
  logic [ptpl_pkg::DIST_W-1:0]    distance;
  logic [ptpl_pkg::IDX_W-1:0]     nearest_index;
  logic                           at_end;
  logic                           valid_res;

  modport source (
    output valid, distance, nearest_index, at_end, valid_res,
    input  ready
  );
  modport sink (
    input  valid, distance, nearest_index, at_end, valid_res,
    output ready
  );
endinterface

`default_nettype wire

FILE: design/point_to_polyline_nearest_segment.sv
// Top level of the point-to-polyline nearest segment block.
// Depends on ptpl_pkg and the channel interfaces in ptpl_if.sv.
`default_nettype none

// Vertices of a polyline arrive one request at a time on the vertex channel,
// each with the query position in signed Q16.16. Every vertex after the first
// closes a segment; the query is projected onto it with the parameter u clamped
// to [0,1] (u = 1 for a segment of near-zero length), and the segment with the
// smallest squared distance is kept, a later segment winning a tie. The vertex
// marked last_point produces one result: the integer square root of the best
// squared distance, the nearest centerline index and the at-end flag, or
// valid_res = 0 when fewer than two vertices were taken. All arithmetic runs on
// one 49x17 multiplier with a 100-bit accumulator and one 67-bit subtractor,
// stepped by a small sequencer, and the vertex channel is not ready while a
// vertex is being worked on. A vertex that starts a polyline, or one beyond
// MAX_POINTS, needs no segment work. A vertex that closes a segment goes from
// acceptance to ready again through prepare, the squared length and the dot
// product in eight multiplier passes, the decision, 16 divider steps, the error
// vector, its squared length in six passes and the compare; when u is clamped
// the divider is skipped. A last vertex adds a setup, 32 square root steps on
// the subtractor, skipped when fewer than two vertices were taken, and loading
// the output register, which waits only while an earlier result is unread.

module point_to_polyline_nearest_segment #(
  parameter int MAX_POINTS = ptpl_pkg::MAX_POINTS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  ptpl_vertex_if.sink   vertex,
  ptpl_result_if.source result
);

  localparam int CNT_W   = $clog2(MAX_POINTS + 1);
  localparam int SEG_W   = $clog2(MAX_POINTS);
  localparam int IDXW    = (SEG_W + 1 > ptpl_pkg::IDX_W) ? SEG_W + 1 : ptpl_pkg::IDX_W;
  localparam int COORD_W = ptpl_pkg::COORD_W;
  localparam int DIFF_W  = ptpl_pkg::DIFF_W;
  localparam int MAG_W   = ptpl_pkg::MAG_W;
  localparam int EMAG_W  = ptpl_pkg::EMAG_W;
  localparam int FRAC_W  = ptpl_pkg::FRAC_W;
  localparam int U_W     = ptpl_pkg::U_W;
  localparam int MUL_A_W = ptpl_pkg::MUL_A_W;
  localparam int MUL_B_W = ptpl_pkg::MUL_B_W;
  localparam int PROD_W  = ptpl_pkg::PROD_W;
  localparam int SH_W    = ptpl_pkg::SH_W;
  localparam int ACC_W   = ptpl_pkg::ACC_W;
  localparam int MSQ_W   = ptpl_pkg::MSQ_W;
  localparam int REM_W   = ptpl_pkg::REM_W;
  localparam int SUB_W   = ptpl_pkg::SUB_W;
  localparam int SQ_W    = ptpl_pkg::SQ_W;
  localparam int STEP_W  = ptpl_pkg::STEP_W;
  localparam int DSQ_LSB = 32;
  localparam int DSQ_MSB = DSQ_LSB + SQ_W - 1;
  localparam int SH_HI   = MUL_B_W;
  localparam int SH_TOP  = 2 * MUL_B_W;

  // Magnitude of an exact coordinate difference; it always fits 32 bits.
  function automatic logic [MAG_W-1:0] diff_mag(input logic [DIFF_W-1:0] d);
    logic [DIFF_W-1:0] n;
    n = ~d + DIFF_W'(1);
    return d[DIFF_W-1] ? n[MAG_W-1:0] : d[MAG_W-1:0];
  endfunction

  // Magnitude of an error component held in the low 50 bits of the accumulator.
  function automatic logic [EMAG_W-1:0] err_mag(input logic [EMAG_W:0] e);
    logic [EMAG_W:0] n;
    n = ~e + (EMAG_W + 1)'(1);
    return e[EMAG_W] ? n[EMAG_W-1:0] : e[EMAG_W-1:0];
  endfunction

  // Sequencer.
  ptpl_pkg::state_t   state, state_next;
  logic [STEP_W-1:0]  step;

  // Polyline state.
  logic [COORD_W-1:0] prev_x, prev_y;
  logic [SQ_W-1:0]    best_dist_sq;
  logic [SEG_W-1:0]   best_seg;
  logic [U_W-1:0]     best_param;
  logic [CNT_W-1:0]   count;
  logic [SEG_W-1:0]   seg_r;
  logic               last_r;

  // Segment operands.
  logic [DIFF_W-1:0]  vx_s, vy_s, wx_s, wy_s;
  logic [MAG_W-1:0]   vxm, vym, wxm, wym;
  logic               vx_neg, vy_neg, wx_neg, wy_neg;
  logic [MSQ_W-1:0]   magsq;
  logic [REM_W-1:0]   rem;
  logic [U_W-1:0]     u;
  logic [EMAG_W-1:0]  exm, eym;

  // Shared multiplier and accumulator.
  logic               mul_go, mul_neg;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [SH_W-1:0]    mul_sh;
  logic [PROD_W-1:0]  prod;
  logic [SH_W-1:0]    prod_sh;
  logic               prod_neg, prod_vld;
  logic               acc_ld;
  logic [ACC_W-1:0]   acc_ld_val;
  logic [ACC_W-1:0]   acc, acc_next, term;

  // Shared subtractor for the compare, the divider and the square root.
  logic [SUB_W-1:0]   sub_lhs, sub_rhs;
  logic [SUB_W:0]     sub_diff;
  logic               sub_ge;

  // Square root.
  logic [SQ_W-1:0]    sq_x, sq_res, sq_one, sq_trial;

  // Output register.
  logic                        out_valid;
  logic [ptpl_pkg::DIST_W-1:0] out_dist;
  logic [ptpl_pkg::IDX_W-1:0]  out_idx;
  logic                        out_end, out_vres;
  logic                        out_load;

  // Request decode and decision terms.
  logic               in_fire, start_poly, take_seg;
  logic               degen, dot_nonpos, clamp;
  logic [SQ_W-1:0]    dsq;
  logic               res_ok, end_flag;
  logic [IDXW-1:0]    idx_w;

  assign in_fire    = vertex.valid && vertex.ready;
  assign start_poly = vertex.first_point || (count == '0);
  assign take_seg   = !start_poly && (count < CNT_W'(MAX_POINTS));

  assign degen      = magsq <= ptpl_pkg::DEGEN_MAX;
  assign dot_nonpos = acc[ACC_W-1] || (acc == '0);
  assign clamp      = degen || dot_nonpos || sub_ge;

  assign sub_diff   = {1'b0, sub_lhs} - {1'b0, sub_rhs};
  assign sub_ge     = !sub_diff[SUB_W];
  assign sq_trial   = sq_res | sq_one;

  // Squared distance of the finished segment, saturated to 64 bits.
  assign dsq = (acc[ACC_W-1:DSQ_MSB+1] != '0) ? '1 : acc[DSQ_MSB:DSQ_LSB];

  assign res_ok   = count >= CNT_W'(2);
  assign end_flag = (CNT_W'(best_seg) == count - CNT_W'(2)) &&
                    (best_param >= ptpl_pkg::AT_END_MIN);
  assign idx_w    = (best_param == '0) ? IDXW'(best_seg) : IDXW'(best_seg) + IDXW'(1);

  assign term = ACC_W'(prod) << prod_sh;

  always_comb begin
    if (acc_ld) begin
      acc_next = acc_ld_val;
    end else if (prod_vld) begin
      acc_next = prod_neg ? acc - term : acc + term;
    end else begin
      acc_next = acc;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ptpl_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (take_seg) begin
            state_next = ptpl_pkg::ST_PREP;
          end else if (vertex.last_point) begin
            state_next = ptpl_pkg::ST_FINAL;
          end
        end
      end
      ptpl_pkg::ST_PREP: state_next = ptpl_pkg::ST_MAG;
      ptpl_pkg::ST_MAG: begin
        if (step == ptpl_pkg::MAG_LAST) state_next = ptpl_pkg::ST_DOT;
      end
      ptpl_pkg::ST_DOT: begin
        if (step == ptpl_pkg::DOT_LAST) state_next = ptpl_pkg::ST_DECIDE;
      end
      ptpl_pkg::ST_DECIDE: begin
        state_next = clamp ? ptpl_pkg::ST_ERR : ptpl_pkg::ST_DIV;
      end
      ptpl_pkg::ST_DIV: begin
        if (step == ptpl_pkg::DIV_LAST) state_next = ptpl_pkg::ST_ERR;
      end
      ptpl_pkg::ST_ERR: begin
        if (step == ptpl_pkg::ERR_LAST) state_next = ptpl_pkg::ST_SQ;
      end
      ptpl_pkg::ST_SQ: begin
        if (step == ptpl_pkg::SQ_LAST) state_next = ptpl_pkg::ST_UPD;
      end
      ptpl_pkg::ST_UPD: begin
        state_next = last_r ? ptpl_pkg::ST_FINAL : ptpl_pkg::ST_IDLE;
      end
      ptpl_pkg::ST_FINAL: begin
        state_next = res_ok ? ptpl_pkg::ST_SQRT : ptpl_pkg::ST_EMIT;
      end
      ptpl_pkg::ST_SQRT: begin
        if (step == ptpl_pkg::SQRT_LAST) state_next = ptpl_pkg::ST_EMIT;
      end
      ptpl_pkg::ST_EMIT: begin
        if (out_load) state_next = ptpl_pkg::ST_IDLE;
      end
      default: state_next = ptpl_pkg::ST_IDLE;
    endcase
  end

  // Control outputs: multiplier passes, accumulator loads, subtractor operands.
  // A pass is issued in one cycle and accumulated in the next, so each phase
  // ends with one drain step and the following phase reads the accumulator.
  always_comb begin
    vertex.ready = (state == ptpl_pkg::ST_IDLE);
    out_load     = (state == ptpl_pkg::ST_EMIT) && (!out_valid || result.ready);
    mul_go       = 1'b0;
    mul_a        = '0;
    mul_b        = '0;
    mul_sh       = '0;
    mul_neg      = 1'b0;
    acc_ld       = 1'b0;
    acc_ld_val   = '0;
    sub_lhs      = '0;
    sub_rhs      = '0;
    case (state)
      ptpl_pkg::ST_MAG: begin
        acc_ld = (step == 5'd0);
        case (step)
          5'd0: begin
            mul_go = 1'b1; mul_a = MUL_A_W'(vxm); mul_b = vxm[MUL_B_W-1:0];
          end
          5'd1: begin
            mul_go = 1'b1; mul_a = MUL_A_W'(vxm);
            mul_b = MUL_B_W'(vxm[MAG_W-1:SH_HI]); mul_sh = SH_W'(SH_HI);
          end
          5'd2: begin
            mul_go = 1'b1; mul_a = MUL_A_W'(vym); mul_b = vym[MUL_B_W-1:0];
          end
          5'd3: begin
            mul_go = 1'b1; mul_a = MUL_A_W'(vym);
            mul_b = MUL_B_W'(vym[MAG_W-1:SH_HI]); mul_sh = SH_W'(SH_HI);
          end
          default: mul_go = 1'b0;
        endcase
      end
      ptpl_pkg::ST_DOT: begin
        acc_ld = (step == 5'd0);
        case (step)
          5'd0: begin
            mul_go = 1'b1; mul_a = MUL_A_W'(wxm); mul_b = vxm[MUL_B_W-1:0];
            mul_neg = wx_neg ^ vx_neg;
          end
          5'd1: begin
            mul_go = 1'b1; mul_a = MUL_A_W'(wxm);
            mul_b = MUL_B_W'(vxm[MAG_W-1:SH_HI]); mul_sh = SH_W'(SH_HI);
            mul_neg = wx_neg ^ vx_neg;
          end
          5'd2: begin
            mul_go = 1'b1; mul_a = MUL_A_W'(wym); mul_b = vym[MUL_B_W-1:0];
            mul_neg = wy_neg ^ vy_neg;
          end
          5'd3: begin
            mul_go = 1'b1; mul_a = MUL_A_W'(wym);
            mul_b = MUL_B_W'(vym[MAG_W-1:SH_HI]); mul_sh = SH_W'(SH_HI);
            mul_neg = wy_neg ^ vy_neg;
          end
          default: mul_go = 1'b0;
        endcase
      end
      ptpl_pkg::ST_DECIDE: begin
        sub_lhs = acc[SUB_W-1:0];
        sub_rhs = SUB_W'(magsq);
      end
      ptpl_pkg::ST_DIV: begin
        sub_lhs = {rem, 1'b0};
        sub_rhs = SUB_W'(magsq);
      end
      ptpl_pkg::ST_ERR: begin
        // e = w * 2^16 - u * v, one component at a time.
        case (step)
          5'd0: begin
            acc_ld = 1'b1;
            acc_ld_val = {{(ACC_W-DIFF_W-FRAC_W){wx_s[DIFF_W-1]}}, wx_s, {FRAC_W{1'b0}}};
            mul_go = 1'b1; mul_a = MUL_A_W'(vxm); mul_b = u; mul_neg = !vx_neg;
          end
          5'd2: begin
            acc_ld = 1'b1;
            acc_ld_val = {{(ACC_W-DIFF_W-FRAC_W){wy_s[DIFF_W-1]}}, wy_s, {FRAC_W{1'b0}}};
            mul_go = 1'b1; mul_a = MUL_A_W'(vym); mul_b = u; mul_neg = !vy_neg;
          end
          default: mul_go = 1'b0;
        endcase
      end
      ptpl_pkg::ST_SQ: begin
        acc_ld = (step == 5'd0);
        case (step)
          5'd0: begin
            mul_go = 1'b1; mul_a = exm; mul_b = exm[MUL_B_W-1:0];
          end
          5'd1: begin
            mul_go = 1'b1; mul_a = exm; mul_b = exm[SH_TOP-1:SH_HI];
            mul_sh = SH_W'(SH_HI);
          end
          5'd2: begin
            mul_go = 1'b1; mul_a = exm; mul_b = MUL_B_W'(exm[EMAG_W-1:SH_TOP]);
            mul_sh = SH_W'(SH_TOP);
          end
          5'd3: begin
            mul_go = 1'b1; mul_a = eym; mul_b = eym[MUL_B_W-1:0];
          end
          5'd4: begin
            mul_go = 1'b1; mul_a = eym; mul_b = eym[SH_TOP-1:SH_HI];
            mul_sh = SH_W'(SH_HI);
          end
          5'd5: begin
            mul_go = 1'b1; mul_a = eym; mul_b = MUL_B_W'(eym[EMAG_W-1:SH_TOP]);
            mul_sh = SH_W'(SH_TOP);
          end
          default: mul_go = 1'b0;
        endcase
      end
      ptpl_pkg::ST_SQRT: begin
        sub_lhs = SUB_W'(sq_x);
        sub_rhs = SUB_W'(sq_trial);
      end
      default: mul_go = 1'b0;
    endcase
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ptpl_pkg::ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= (state_next != state) ? '0 : step + STEP_W'(1);
    end
  end

  // Multiplier stage and accumulator.
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= mul_go;
    end
    prod     <= mul_a * mul_b;
    prod_sh  <= mul_sh;
    prod_neg <= mul_neg;
    acc      <= acc_next;
  end

  // Polyline state: start, segment bookkeeping, best update and clearing
  // once the result has been handed to the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x       <= '0;
      prev_y       <= '0;
      best_dist_sq <= '1;
      best_seg     <= '0;
      best_param   <= '0;
      count        <= '0;
    end else begin
      if (in_fire) begin
        if (start_poly) begin
          count        <= CNT_W'(1);
          prev_x       <= vertex.point_x;
          prev_y       <= vertex.point_y;
          best_dist_sq <= '1;
          best_seg     <= '0;
          best_param   <= '0;
        end else if (take_seg) begin
          prev_x <= vertex.point_x;
          prev_y <= vertex.point_y;
          count  <= count + CNT_W'(1);
        end
      end
      if (state == ptpl_pkg::ST_UPD && dsq <= best_dist_sq) begin
        best_dist_sq <= dsq;
        best_seg     <= seg_r;
        best_param   <= u;
      end
      if (out_load) begin
        count        <= '0;
        best_dist_sq <= '1;
      end
    end
  end

  // Segment datapath registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      last_r <= vertex.last_point;
      seg_r  <= SEG_W'(count - CNT_W'(1));
      vx_s   <= {vertex.point_x[COORD_W-1], vertex.point_x} - {prev_x[COORD_W-1], prev_x};
      vy_s   <= {vertex.point_y[COORD_W-1], vertex.point_y} - {prev_y[COORD_W-1], prev_y};
      wx_s   <= {vertex.query_x[COORD_W-1], vertex.query_x} - {prev_x[COORD_W-1], prev_x};
      wy_s   <= {vertex.query_y[COORD_W-1], vertex.query_y} - {prev_y[COORD_W-1], prev_y};
    end
    if (state == ptpl_pkg::ST_PREP) begin
      vxm    <= diff_mag(vx_s);
      vym    <= diff_mag(vy_s);
      wxm    <= diff_mag(wx_s);
      wym    <= diff_mag(wy_s);
      vx_neg <= vx_s[DIFF_W-1];
      vy_neg <= vy_s[DIFF_W-1];
      wx_neg <= wx_s[DIFF_W-1];
      wy_neg <= wy_s[DIFF_W-1];
    end
    if (state == ptpl_pkg::ST_DOT && step == 5'd0) begin
      magsq <= acc[MSQ_W-1:0];
    end
    if (state == ptpl_pkg::ST_DECIDE) begin
      // Degenerate segments and dot products past the far end clamp to one.
      rem <= acc[REM_W-1:0];
      if (degen) begin
        u <= ptpl_pkg::U_ONE;
      end else if (dot_nonpos) begin
        u <= '0;
      end else if (sub_ge) begin
        u <= ptpl_pkg::U_ONE;
      end else begin
        u <= '0;
      end
    end
    if (state == ptpl_pkg::ST_DIV) begin
      // Restoring division, one quotient bit per step.
      if (sub_ge) begin
        rem <= sub_diff[REM_W-1:0];
        u   <= {u[U_W-2:0], 1'b1};
      end else begin
        rem <= sub_lhs[REM_W-1:0];
        u   <= {u[U_W-2:0], 1'b0};
      end
    end
    if (state == ptpl_pkg::ST_ERR && step == 5'd2) begin
      exm <= err_mag(acc[EMAG_W:0]);
    end
    if (state == ptpl_pkg::ST_SQ && step == 5'd0) begin
      eym <= err_mag(acc[EMAG_W:0]);
    end
  end

  // Integer square root, two radicand bits per step.
  always_ff @(posedge clk) begin
    if (state == ptpl_pkg::ST_FINAL) begin
      sq_x   <= best_dist_sq;
      sq_res <= '0;
      sq_one <= ptpl_pkg::SQRT_ONE;
    end else if (state == ptpl_pkg::ST_SQRT) begin
      if (sub_ge) begin
        sq_x   <= sub_diff[SQ_W-1:0];
        sq_res <= (sq_res >> 1) | sq_one;
      end else begin
        sq_res <= sq_res >> 1;
      end
      sq_one <= sq_one >> 2;
    end
  end

  // Output register; a new result loads only when the previous one is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      out_vres <= res_ok;
      out_dist <= res_ok ? sq_res[ptpl_pkg::DIST_W-1:0] : '0;
      out_idx  <= res_ok ? idx_w[ptpl_pkg::IDX_W-1:0] : '0;
      out_end  <= res_ok && end_flag;
    end
  end

  assign result.valid         = out_valid;
  assign result.distance      = out_dist;
  assign result.nearest_index = out_idx;
  assign result.at_end        = out_end;
  assign result.valid_res     = out_vres;

  // The divider remainder stays below the divisor at every step.
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == ptpl_pkg::ST_DIV) |-> (rem < REM_W'(magsq)))
    else $error("divider remainder reached the divisor");

  // A sum of squares never comes out negative.
  a_sum_pos: assert property (@(posedge clk) disable iff (rst)
    (state == ptpl_pkg::ST_UPD) |-> !acc[ACC_W-1])
    else $error("squared distance accumulated negative");

  // Handing over a result clears the polyline state.
  a_clear: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (count == '0) && (best_dist_sq == '1))
    else $error("polyline state not cleared after a result");

  // A result without two vertices carries zero fields.
  a_short: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.valid_res) |->
      (result.distance == '0) && (result.nearest_index == '0) && !result.at_end)
    else $error("short polyline result has nonzero fields");

endmodule

`default_nettype wire

FILE: tb/tb_point_to_polyline_nearest_segment.sv
// Self-checking testbench for point_to_polyline_nearest_segment.
// Depends on ptpl_pkg, the channel interfaces in ptpl_if.sv and the top level RTL.
`default_nettype none

module tb_point_to_polyline_nearest_segment;
  timeunit 1ns;
  timeprecision 1ps;

  import ptpl_pkg::*;

  // One meter and half a meter in Q16.16, and the ends of the coordinate range.
  localparam logic signed [COORD_W-1:0] ONE_M  = 32'sd65536;
  localparam logic signed [COORD_W-1:0] HALF_M = 32'sd32768;
  localparam logic signed [COORD_W-1:0] MIN_C  = 32'sh8000_0000;
  localparam logic signed [COORD_W-1:0] MAX_C  = 32'sh7fff_ffff;

  // The long polyline runs past MAX_POINTS so that the tail is dropped.
  localparam int LONG_LEN = MAX_POINTS_DEF + 6;

  localparam int RANDOM_ITEMS = 450;
  localparam int HOLD_AT      = 40;     // result count that starts the long stall
  localparam int LONG_HOLD    = 1500;   // cycles the result side stays blocked
  localparam int IDLE_LIMIT   = 5000;   // cycles without any handshake
  localparam int SETTLE       = 100;    // longest vertex plus the square root, rounded up

  typedef struct {
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] qx;
    logic signed [COORD_W-1:0] qy;
    logic                      first_point;
    logic                      last_point;
  } vertex_t;

  typedef struct {
    logic [DIST_W-1:0] distance;
    logic [IDX_W-1:0]  nearest_index;
    logic              at_end;
    logic              valid_res;
  } polyline_result_t;

  // How the coordinates of a random polyline are spread.
  typedef enum {SPAN_FULL, SPAN_METERS, SPAN_TINY, SPAN_EXTREME} span_t;

  // How the result side accepts when it is not in the long stall.
  typedef enum {RX_OPEN, RX_CHOPPY, RX_SPARSE} rx_mode_t;

  logic clk;
  logic rst;

  ptpl_vertex_if vertex_ch ();
  ptpl_result_if result_ch ();

  point_to_polyline_nearest_segment u_dut (
    .clk    (clk),
    .rst    (rst),
    .vertex (vertex_ch),
    .result (result_ch)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  vertex_t          pending_vertices[$];
  polyline_result_t expected_results[$];

  int results_seen;
  int mismatches = 0;

  // Mirror of the block's polyline state, updated on every accepted vertex request.
  longint      prev_x, prev_y;
  logic [63:0] best_dsq;
  int          best_seg, best_u, nverts;

  // Applies one accepted vertex to the mirrored state. Returns 1 when the vertex
  // closes a polyline, with the result the block has to produce in r.
  function automatic bit advance_polyline(input vertex_t v, output polyline_result_t r);
    longint              vx, vy, wx, wy, ex, ey;
    logic signed [127:0] bvx, bvy, bwx, bwy, bex, bey, magsq, dot, esum;
    logic [63:0]         dsq, root, trial;
    int                  u, b;
    r = '{default: '0};
    if (v.first_point || nverts == 0) begin
      // A flagged start, or any vertex while nothing is open, begins a polyline.
      nverts   = 1;
      prev_x   = v.px;
      prev_y   = v.py;
      best_dsq = '1;
      best_seg = 0;
      best_u   = 0;
    end else if (nverts < MAX_POINTS_DEF) begin
      vx = longint'(v.px) - prev_x;
      vy = longint'(v.py) - prev_y;
      wx = longint'(v.qx) - prev_x;
      wy = longint'(v.qy) - prev_y;
      bvx = vx;
      bvy = vy;
      bwx = wx;
      bwy = wy;
      magsq = bvx * bvx + bvy * bvy;
      dot   = bwx * bvx + bwy * bvy;
      // A segment of near-zero length projects onto its far end.
      if (magsq <= DEGEN_MAX) u = U_ONE;
      else if (dot <= 0) u = 0;
      else if (dot >= magsq) u = U_ONE;
      else u = int'((dot * 65536) / magsq);
      ex = wx * 65536 - longint'(u) * vx;
      ey = wy * 65536 - longint'(u) * vy;
      bex = ex;
      bey = ey;
      esum = bex * bex + bey * bey;
      dsq = (esum[127:96] != 0) ? '1 : esum[95:32];
      // The later segment wins a tie.
      if (dsq <= best_dsq) begin
        best_dsq = dsq;
        best_seg = nverts - 1;
        best_u   = u;
      end
      prev_x = v.px;
      prev_y = v.py;
      nverts++;
    end
    if (!v.last_point) return 1'b0;
    if (nverts >= 2) begin
      root = '0;
      for (b = 31; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial * trial <= best_dsq) root = trial;
      end
      r.distance      = root;
      r.nearest_index = (best_u == 0) ? best_seg : best_seg + 1;
      r.at_end        = (best_seg == nverts - 2) && (best_u >= AT_END_MIN);
      r.valid_res     = 1'b1;
    end
    nverts   = 0;
    best_dsq = '1;
    return 1'b1;
  endfunction

  task automatic add_vertex(input logic signed [COORD_W-1:0] px, py, qx, qy,
                            input bit first_point, last_point);
    pending_vertices.push_back('{px, py, qx, qy, first_point, last_point});
  endtask

  function automatic logic signed [COORD_W-1:0] pick_coord(
      input span_t span, input logic signed [COORD_W-1:0] center);
    case (span)
      SPAN_FULL:   return $urandom;
      SPAN_METERS: return center + $signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
      SPAN_TINY:   return center + $signed($urandom_range(0, 6)) - 3;
      default: begin
        case ($urandom_range(0, 4))
          0:       return MIN_C;
          1:       return MAX_C;
          2:       return '0;
          3:       return '1;
          default: return $urandom;
        endcase
      end
    endcase
  endfunction

  // A well-formed polyline most of the time, with the odd missing start, restart
  // in the middle or missing end mark mixed in as noise.
  task automatic random_polyline(input int n);
    span_t                     span;
    logic signed [COORD_W-1:0] cx, cy, qx, qy;
    bit                        first_point, last_point;
    int                        i;
    span = span_t'($urandom_range(0, 3));
    cx = $urandom;
    cy = $urandom;
    qx = pick_coord(span, cx);
    qy = pick_coord(span, cy);
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        qx = pick_coord(span, cx);
        qy = pick_coord(span, cy);
      end
      first_point = (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 39) == 0);
      last_point  = (i == n - 1) && ($urandom_range(0, 19) != 0);
      add_vertex(pick_coord(span, cx), pick_coord(span, cy), qx, qy, first_point, last_point);
    end
  endtask

  // Vertex driver. Requests go out in bursts of random length separated by
  // random gaps, some of them zero so that long gapless runs occur. The mirror
  // is advanced at the edge where a request is accepted, which is also where
  // any expected result is queued.
  vertex_t offered;
  int      burst_left;
  int      gap_left;

  always @(posedge clk) begin : drive_vertices
    polyline_result_t produced;
    if (rst) begin
      vertex_ch.valid <= 1'b0;
      burst_left      <= 1;
      gap_left        <= 0;
    end else begin
      if (vertex_ch.valid && vertex_ch.ready) begin
        if (advance_polyline(offered, produced)) expected_results.push_back(produced);
      end
      if (!vertex_ch.valid || vertex_ch.ready) begin
        if (gap_left != 0) begin
          gap_left        <= gap_left - 1;
          vertex_ch.valid <= 1'b0;
        end else if (pending_vertices.size() != 0) begin
          offered = pending_vertices.pop_front();
          vertex_ch.point_x     <= offered.px;
          vertex_ch.point_y     <= offered.py;
          vertex_ch.query_x     <= offered.qx;
          vertex_ch.query_y     <= offered.qy;
          vertex_ch.first_point <= offered.first_point;
          vertex_ch.last_point  <= offered.last_point;
          vertex_ch.valid       <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          vertex_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result side. It switches between accepting every cycle, accepting at random
  // and accepting rarely. Once, after HOLD_AT results, it blocks for the LONG_HOLD
  // stretch while the sender keeps offering, so the output register stays full
  // and the vertex channel has to stall.
  rx_mode_t rx_mode;
  int       mode_left;
  int       hold_left;
  bit       hold_done;

  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      rx_mode         <= RX_OPEN;
      mode_left       <= 0;
      hold_left       <= 0;
      hold_done       <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   <= rx_mode_t'($urandom_range(0, 2));
        mode_left <= $urandom_range(16, 96);
      end else begin
        mode_left <= mode_left - 1;
      end
      if (!hold_done && results_seen == HOLD_AT) begin
        hold_done       <= 1'b1;
        hold_left       <= LONG_HOLD;
        result_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left       <= hold_left - 1;
        result_ch.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_OPEN:   result_ch.ready <= 1'b1;
          RX_CHOPPY: result_ch.ready <= $urandom_range(0, 1);
          default:   result_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Every accepted result is checked field by field against the oldest
  // expectation; a result with none waiting is a failure on its own.
  always @(posedge clk) begin : check_results
    polyline_result_t want;
    if (rst) begin
      results_seen <= 0;
    end else if (result_ch.valid && result_ch.ready) begin
      results_seen <= results_seen + 1;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, none pending: distance %0d index %0d at_end %0b valid %0b",
                 $time, result_ch.distance, result_ch.nearest_index, result_ch.at_end,
                 result_ch.valid_res);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (result_ch.distance !== want.distance) begin
          $display("%0t: distance expected %0d, actual %0d", $time, want.distance,
                   result_ch.distance);
          mismatches++;
        end
        if (result_ch.nearest_index !== want.nearest_index) begin
          $display("%0t: nearest_index expected %0d, actual %0d", $time, want.nearest_index,
                   result_ch.nearest_index);
          mismatches++;
        end
        if (result_ch.at_end !== want.at_end) begin
          $display("%0t: at_end expected %0b, actual %0b", $time, want.at_end,
                   result_ch.at_end);
          mismatches++;
        end
        if (result_ch.valid_res !== want.valid_res) begin
          $display("%0t: valid_res expected %0b, actual %0b", $time, want.valid_res,
                   result_ch.valid_res);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: a long run of cycles with no handshake on either side means the
  // block has hung or lost a result.
  int idle_cycles;

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((vertex_ch.valid && vertex_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus. Each phase is queued at once and the sender then pauses until
  // every request has gone out and every expected result has come back.
  initial begin
    int i, n, random_items;
    rst                   = 1'b1;
    vertex_ch.valid       = 1'b0;
    vertex_ch.point_x     = '0;
    vertex_ch.point_y     = '0;
    vertex_ch.query_x     = '0;
    vertex_ch.query_y     = '0;
    vertex_ch.first_point = 1'b0;
    vertex_ch.last_point  = 1'b0;
    result_ch.ready       = 1'b0;
    nverts                = 0;
    prev_x                = 0;
    prev_y                = 0;
    best_dsq              = '1;
    best_seg              = 0;
    best_u                = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // A polyline that opens without its start flag, right after reset. The
    // query sits a meter off the middle of the segment.
    add_vertex(0, 0, HALF_M, ONE_M, 0, 0);
    add_vertex(ONE_M, 0, HALF_M, ONE_M, 0, 1);
    // Single vertex, flagged as both ends, and a bare end mark with nothing open.
    add_vertex(3 * ONE_M, -2 * ONE_M, 0, 0, 1, 1);
    add_vertex(ONE_M, ONE_M, 0, 0, 0, 1);
    // A restart in the middle drops the first polyline without a result.
    add_vertex(5 * ONE_M, 5 * ONE_M, 0, 0, 1, 0);
    add_vertex(6 * ONE_M, 5 * ONE_M, 0, 0, 0, 0);
    add_vertex(0, 0, HALF_M, 0, 1, 0);
    add_vertex(ONE_M, 0, HALF_M, 0, 0, 1);
    // A near-zero-length segment (u forced to one) ties with the next segment,
    // whose projection clamps to zero; the later one must win.
    add_vertex(0, 0, -ONE_M, 0, 1, 0);
    add_vertex(1, 1, -ONE_M, 0, 0, 0);
    add_vertex(ONE_M, 0, -ONE_M, 0, 0, 0);
    add_vertex(2 * ONE_M, 0, -ONE_M, 0, 0, 1);
    // Projection past the end clamps u to one.
    add_vertex(0, 0, 3 * ONE_M, 0, 1, 0);
    add_vertex(ONE_M, 0, 3 * ONE_M, 0, 0, 1);
    // On a one-meter segment u equals the query x, so these sit on either side
    // of the at-end threshold.
    add_vertex(0, 0, 32'sd65532, ONE_M, 1, 0);
    add_vertex(ONE_M, 0, 32'sd65532, ONE_M, 0, 1);
    add_vertex(0, 0, 32'sd65529, 0, 1, 0);
    add_vertex(ONE_M, 0, 32'sd65529, 0, 0, 1);
    // Out and back along the same segment: an exact tie between two segments.
    add_vertex(0, 0, HALF_M, ONE_M, 1, 0);
    add_vertex(ONE_M, 0, HALF_M, ONE_M, 0, 0);
    add_vertex(0, 0, HALF_M, ONE_M, 0, 1);
    // Opposite corners of the coordinate range: the squared distance saturates.
    add_vertex(MIN_C, MIN_C, MAX_C, MAX_C, 1, 0);
    add_vertex(MIN_C, MIN_C, MAX_C, MAX_C, 0, 1);
    // The longest possible segment.
    add_vertex(MAX_C, MAX_C, 0, 0, 1, 0);
    add_vertex(MIN_C, MIN_C, 0, 0, 0, 1);
    while (pending_vertices.size() != 0 || vertex_ch.valid || expected_results.size() != 0)
      @(posedge clk);

    // A straight line one meter per vertex that runs past MAX_POINTS. The
    // vertices past the limit are ignored, the end mark on the last of them still
    // closes the polyline, and the query just beyond the last kept vertex gives
    // the highest centerline index with the at-end flag set.
    for (i = 0; i < LONG_LEN; i++)
      add_vertex(i * ONE_M, 0, (MAX_POINTS_DEF - 1) * ONE_M + HALF_M, 0, i == 0,
                 i == LONG_LEN - 1);
    while (pending_vertices.size() != 0 || vertex_ch.valid || expected_results.size() != 0)
      @(posedge clk);

    // Random polylines, mostly short, a few longer.
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 5);
      random_polyline(n);
      random_items += n;
    end
    while (pending_vertices.size() != 0 || vertex_ch.valid || expected_results.size() != 0)
      @(posedge clk);

    // Give a vertex that produces no result time to finish, and any stray
    // result time to show up.
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
